// File: rtl/rpn_pkg.sv
// ============================================================================
// rpn_pkg: shared types and constants of the RMS power normalizer
// Transaction structs, status codes, sequencer states and step-unit types.
// ============================================================================
package rpn_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int MAG_W           = SAMPLE_W + 1;
    localparam int SQ_W            = 2 * SAMPLE_W - 1;
    localparam int SUM_W           = 51;
    localparam int MAX_REF_SAMPLES = 1048576;
    localparam int CNT_W           = $clog2(MAX_REF_SAMPLES + 1);
    localparam int RMS_W           = 16;
    localparam int OUT_W           = 16;
    localparam int FRAC_SHIFT      = 12;
    localparam int REM_W           = CNT_W + 1;
    localparam int QUOT_W          = 2 * RMS_W;
    localparam int ITER_W          = $clog2(QUOT_W);
    // Mean square is (sum << 2) / count; bits at and above 2^32 of the dividend
    localparam int MEAN_HI_LSB     = QUOT_W - 2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SAT   = 2'd1;
    localparam logic [1:0] STATUS_NOREF = 2'd2;

    localparam logic ACTION_REFERENCE = 1'b0;
    localparam logic ACTION_NORMALIZE = 1'b1;

    typedef struct packed {
        logic                       action;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_reference;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] normalized;
        logic [1:0]              status;
    } out_item_t;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_SQUARE = 10'b00_0000_0010,
        ST_ACCUM  = 10'b00_0000_0100,
        ST_FINISH = 10'b00_0000_1000,
        ST_RDIV   = 10'b00_0001_0000,
        ST_SQRT   = 10'b00_0010_0000,
        ST_NCHK   = 10'b00_0100_0000,
        ST_NDIV   = 10'b00_1000_0000,
        ST_NFIN   = 10'b01_0000_0000,
        ST_EMIT   = 10'b10_0000_0000
    } state_t;

    typedef enum logic {
        STEP_DIV  = 1'b0,
        STEP_SQRT = 1'b1
    } step_mode_t;

    typedef struct packed {
        step_mode_t       mode;
        logic [REM_W-1:0] rem;
        logic [1:0]       bits;
        logic [CNT_W-1:0] divisor;
        logic [RMS_W-1:0] root;
    } step_in_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic             ge;
    } step_out_t;

endpackage

// File: rtl/rpn_step_unit.sv
// ============================================================================
// rpn_step_unit: shared compare-subtract step
// One restoring division step or one digit-by-digit square root step.
// ============================================================================
module rpn_step_unit (
    input  rpn_pkg::step_in_t  step_in,
    output rpn_pkg::step_out_t step_out
);

    logic [rpn_pkg::REM_W-1:0] shifted;
    logic [rpn_pkg::REM_W-1:0] trial;

    // Shift in the next dividend bit or radicand bit pair and form the trial term
    always_comb begin
        if (step_in.mode == rpn_pkg::STEP_SQRT) begin
            shifted = {step_in.rem[rpn_pkg::REM_W-3:0], step_in.bits};
            trial   = rpn_pkg::REM_W'({step_in.root, 2'b01});
        end else begin
            shifted = {step_in.rem[rpn_pkg::REM_W-2:0], step_in.bits[1]};
            trial   = rpn_pkg::REM_W'(step_in.divisor);
        end
    end

    // Subtract when the trial term fits
    always_comb begin
        step_out.ge  = (shifted >= trial);
        step_out.rem = step_out.ge ? (shifted - trial) : shifted;
    end

endmodule

// File: rtl/rpn_core.sv
// ============================================================================
// rpn_core: sequencer and state of the RMS power normalizer
// Accumulates reference power, derives the RMS and divides target samples,
// driving the shared step unit one bit per cycle.
// ============================================================================
module rpn_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rpn_pkg::in_item_t  s_item,
    output logic               res_valid,
    output rpn_pkg::out_item_t res_item,
    input  logic               res_take
);

    rpn_pkg::state_t state_reg, state_next;

    logic [rpn_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [rpn_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [rpn_pkg::RMS_W-1:0]  rms_reg, rms_next;
    logic                       ref_done_reg, ref_done_next;

    logic [rpn_pkg::MAG_W-1:0]  mag_reg, mag_next;
    logic                       sign_reg, sign_next;
    logic                       last_reg, last_next;
    logic [rpn_pkg::SQ_W-1:0]   sq_reg, sq_next;
    logic [rpn_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [rpn_pkg::QUOT_W-1:0] quot_reg, quot_next;
    logic [rpn_pkg::RMS_W-1:0]  root_reg, root_next;
    logic [rpn_pkg::ITER_W-1:0] iter_reg, iter_next;
    rpn_pkg::out_item_t         res_reg, res_next;

    logic signed [rpn_pkg::MAG_W-1:0] sample_ext;
    logic [rpn_pkg::MAG_W-1:0]        mag_in;
    logic [2*rpn_pkg::MAG_W-1:0]      sq_full;
    logic [rpn_pkg::SUM_W:0]          sum_add;
    logic [rpn_pkg::RMS_W-1:0]        quot_lo;
    rpn_pkg::step_in_t                step_in;
    rpn_pkg::step_out_t               step_out;

    // Magnitude of the incoming sample
    always_comb begin
        sample_ext = rpn_pkg::MAG_W'(s_item.sample);
        mag_in     = sample_ext[rpn_pkg::MAG_W-1] ? (~sample_ext + 1'b1) : sample_ext;
    end

    assign sq_full = mag_reg * mag_reg;
    assign sum_add = {1'b0, sum_reg} + (rpn_pkg::SUM_W + 1)'(sq_reg);
    assign quot_lo = quot_reg[rpn_pkg::RMS_W-1:0];

    // Feed the shared step unit
    always_comb begin
        step_in.mode    = (state_reg == rpn_pkg::ST_SQRT) ? rpn_pkg::STEP_SQRT
                                                          : rpn_pkg::STEP_DIV;
        step_in.rem     = rem_reg;
        step_in.bits    = quot_reg[rpn_pkg::QUOT_W-1 -: 2];
        step_in.divisor = (state_reg == rpn_pkg::ST_RDIV) ? count_reg
                                                          : rpn_pkg::CNT_W'(rms_reg);
        step_in.root    = root_reg;
    end

    rpn_step_unit u_step (
        .step_in  (step_in),
        .step_out (step_out)
    );

    assign s_ready   = (state_reg == rpn_pkg::ST_IDLE);
    assign res_valid = (state_reg == rpn_pkg::ST_EMIT);
    assign res_item  = res_reg;

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        rms_next      = rms_reg;
        ref_done_next = ref_done_reg;
        mag_next      = mag_reg;
        sign_next     = sign_reg;
        last_next     = last_reg;
        sq_next       = sq_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        root_next     = root_reg;
        iter_next     = iter_reg;
        res_next      = res_reg;

        unique case (state_reg)
            rpn_pkg::ST_IDLE: begin
                if (s_valid) begin
                    mag_next  = mag_in;
                    sign_next = s_item.sample[rpn_pkg::SAMPLE_W-1];
                    last_next = s_item.last_reference;
                    if (s_item.action == rpn_pkg::ACTION_REFERENCE) begin
                        // Start a new set after a finished one
                        if (ref_done_reg) begin
                            sum_next      = '0;
                            count_next    = '0;
                            ref_done_next = 1'b0;
                        end
                        state_next = rpn_pkg::ST_SQUARE;
                    end else if (!ref_done_reg || (rms_reg == '0)) begin
                        res_next.normalized = '0;
                        res_next.status     = rpn_pkg::STATUS_NOREF;
                        state_next          = rpn_pkg::ST_EMIT;
                    end else begin
                        state_next = rpn_pkg::ST_NCHK;
                    end
                end
            end
            rpn_pkg::ST_SQUARE: begin
                sq_next    = sq_full[rpn_pkg::SQ_W-1:0];
                state_next = rpn_pkg::ST_ACCUM;
            end
            rpn_pkg::ST_ACCUM: begin
                // Add with saturation while the set has room
                if (count_reg < rpn_pkg::CNT_W'(rpn_pkg::MAX_REF_SAMPLES)) begin
                    sum_next   = sum_add[rpn_pkg::SUM_W] ? '1 : sum_add[rpn_pkg::SUM_W-1:0];
                    count_next = count_reg + 1'b1;
                end
                state_next = last_reg ? rpn_pkg::ST_FINISH : rpn_pkg::ST_IDLE;
            end
            rpn_pkg::ST_FINISH: begin
                ref_done_next = 1'b1;
                if (count_reg == '0) begin
                    rms_next   = '0;
                    state_next = rpn_pkg::ST_IDLE;
                end else if (sum_reg[rpn_pkg::SUM_W-1:rpn_pkg::MEAN_HI_LSB] >= count_reg) begin
                    // Mean square at or above 2^32: RMS clamps to full scale
                    rms_next   = '1;
                    state_next = rpn_pkg::ST_IDLE;
                end else begin
                    rem_next   = rpn_pkg::REM_W'(sum_reg[rpn_pkg::SUM_W-1:rpn_pkg::MEAN_HI_LSB]);
                    quot_next  = {sum_reg[rpn_pkg::MEAN_HI_LSB-1:0], 2'b00};
                    iter_next  = '1;
                    state_next = rpn_pkg::ST_RDIV;
                end
            end
            rpn_pkg::ST_RDIV: begin
                rem_next  = step_out.rem;
                quot_next = {quot_reg[rpn_pkg::QUOT_W-2:0], step_out.ge};
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0) begin
                    rem_next   = '0;
                    root_next  = '0;
                    iter_next  = rpn_pkg::ITER_W'(rpn_pkg::RMS_W - 1);
                    state_next = rpn_pkg::ST_SQRT;
                end
            end
            rpn_pkg::ST_SQRT: begin
                rem_next  = step_out.rem;
                root_next = {root_reg[rpn_pkg::RMS_W-2:0], step_out.ge};
                quot_next = {quot_reg[rpn_pkg::QUOT_W-3:0], 2'b00};
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0) begin
                    rms_next   = {root_reg[rpn_pkg::RMS_W-2:0], step_out.ge};
                    state_next = rpn_pkg::ST_IDLE;
                end
            end
            rpn_pkg::ST_NCHK: begin
                // Quotient of 2^16 or more always saturates
                if ((rpn_pkg::MAG_W + 3)'(mag_reg) >= {rms_reg, 4'b0000}) begin
                    res_next.normalized = sign_reg ? {1'b1, {(rpn_pkg::OUT_W-1){1'b0}}}
                                                   : {1'b0, {(rpn_pkg::OUT_W-1){1'b1}}};
                    res_next.status     = rpn_pkg::STATUS_SAT;
                    state_next          = rpn_pkg::ST_EMIT;
                end else begin
                    rem_next   = rpn_pkg::REM_W'(mag_reg >> 4);
                    quot_next  = {mag_reg[3:0], {rpn_pkg::FRAC_SHIFT{1'b0}},
                                  {rpn_pkg::RMS_W{1'b0}}};
                    iter_next  = rpn_pkg::ITER_W'(rpn_pkg::RMS_W - 1);
                    state_next = rpn_pkg::ST_NDIV;
                end
            end
            rpn_pkg::ST_NDIV: begin
                rem_next  = step_out.rem;
                quot_next = {quot_reg[rpn_pkg::QUOT_W-2:0], step_out.ge};
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0) begin
                    state_next = rpn_pkg::ST_NFIN;
                end
            end
            rpn_pkg::ST_NFIN: begin
                // Apply sign and clamp to Q3.12 range
                res_next.status = rpn_pkg::STATUS_OK;
                if (sign_reg) begin
                    if (quot_lo > 16'h8000) begin
                        res_next.normalized = 16'sh8000;
                        res_next.status     = rpn_pkg::STATUS_SAT;
                    end else begin
                        res_next.normalized = ~quot_lo + 1'b1;
                    end
                end else begin
                    if (quot_lo > 16'h7FFF) begin
                        res_next.normalized = 16'sh7FFF;
                        res_next.status     = rpn_pkg::STATUS_SAT;
                    end else begin
                        res_next.normalized = quot_lo;
                    end
                end
                state_next = rpn_pkg::ST_EMIT;
            end
            rpn_pkg::ST_EMIT: begin
                if (res_take) begin
                    state_next = rpn_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rpn_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and model state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rpn_pkg::ST_IDLE;
            sum_reg      <= '0;
            count_reg    <= '0;
            rms_reg      <= '0;
            ref_done_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            rms_reg      <= rms_next;
            ref_done_reg <= ref_done_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        sign_reg <= sign_next;
        last_reg <= last_next;
        sq_reg   <= sq_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        root_reg <= root_next;
        iter_reg <= iter_next;
        res_reg  <= res_next;
    end

endmodule

// File: rtl/rms_power_normalizer.sv
// ============================================================================
// rms_power_normalizer: top level of the RMS power normalizer
// Normalizes target samples by the RMS of a loaded reference set.
// ============================================================================
// Usage:
//   s_ channel: one transaction per sample. action 0 loads a reference sample,
//   last_reference marks the end of the set; action 1 normalizes a target.
//   m_ channel: one transaction per normalize item (normalized Q3.12, status);
//   reference items give none.
// Sequence:
//   A reference sample is squared and accumulated before s_ready returns.
//   A last reference adds a finishing step, plus the division and square root
//   steps when the mean square stays below full scale.
//   A normalize item runs a range check, 16 division steps and a sign and
//   clamp step; with no reference power it goes straight to its result, and
//   a quotient far out of range ends at the range check. The shared
//   compare-subtract step unit delivers one quotient or root bit per cycle.
// Reset:
//   aresetn low clears the accumulated power, the count and the RMS, so
//   normalize items report no reference power until a set is finished.
// Stall:
//   A result waits in the output register while m_ready is low; the core may
//   take and process the next item, then holds its own result until the
//   output register frees.
// ============================================================================
module rms_power_normalizer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rpn_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output rpn_pkg::out_item_t m_item
);

    logic               res_valid;
    logic               res_take;
    rpn_pkg::out_item_t res_item;
    logic               m_valid_reg, m_valid_next;
    rpn_pkg::out_item_t m_item_reg, m_item_next;

    rpn_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .res_valid (res_valid),
        .res_item  (res_item),
        .res_take  (res_take)
    );

    // Load the output register when it is empty or being drained
    assign res_take = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (res_take) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_item_next = res_item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// File: rtl/rpn_checker.sv
// ============================================================================
// rpn_checker: port-level checks of the RMS power normalizer
// Watches the top-level channels and flags inconsistent results.
// ============================================================================
module rpn_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input rpn_pkg::out_item_t m_item
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // Drop ready after each accepted transaction
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // No-power result carries zero
    a_noref_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.status == rpn_pkg::STATUS_NOREF) |-> (m_item.normalized == '0))
        else $error("no-power result is not zero");

    // Saturated result sits on a bound
    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.status == rpn_pkg::STATUS_SAT) |->
            (m_item.normalized == 16'sh7FFF) || (m_item.normalized == 16'sh8000))
        else $error("saturated result off bound");

    // Status stays within its codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.status == rpn_pkg::STATUS_OK) ||
                    (m_item.status == rpn_pkg::STATUS_SAT) ||
                    (m_item.status == rpn_pkg::STATUS_NOREF))
        else $error("undefined status code");

endmodule

bind rms_power_normalizer rpn_checker u_rpn_checker (.*);
